### sv/csv_field_tokenizer_defines.svh
// Assertion macros shared by the tokenizer modules.
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSVFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSVFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/csvft_pkg.sv
package csvft_pkg;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_FIELD    = 2'd1;
  localparam logic [1:0] KIND_ROW      = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } res_t;

  // one queue entry: the results of one input transaction
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } ent_t;

endpackage

### sv/csvft_front.sv
`include "csv_field_tokenizer_defines.svh"

module csvft_front #(
  parameter int MAX_FIELD = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output csvft_pkg::ent_t    q_ent
);

  localparam int LEN_W = $clog2(MAX_FIELD + 1);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_FIELD - 1);
  localparam logic [LEN_W-1:0] LEN_OVF  = LEN_W'(MAX_FIELD);

  logic             skip_header_r;
  logic             in_header_r, in_header_nxt;
  logic             header_quoted_r, header_quoted_nxt;
  logic             quoted_r, quoted_nxt;
  logic             quote_pending_r, quote_pending_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;
  logic             row_open_r, row_open_nxt;
  logic [1:0]       n_res;
  csvft_pkg::res_t  r0, r1;
  logic             acc;
  logic             cfg_wr;

  function automatic void push_res(inout csvft_pkg::res_t a, inout csvft_pkg::res_t b,
                                   inout logic [1:0] n, input logic [1:0] kind,
                                   input logic [7:0] ch);
    csvft_pkg::res_t x;
    x.kind = kind;
    x.ch   = ch;
    if (n == 2'd0) begin
      a = x;
    end else begin
      b = x;
    end
    n = n + 2'd1;
  endfunction

  function automatic void put_char(inout csvft_pkg::res_t a, inout csvft_pkg::res_t b,
                                   inout logic [1:0] n, inout logic [LEN_W-1:0] len,
                                   input logic [7:0] ch);
    if (len < LEN_LAST) begin
      push_res(a, b, n, csvft_pkg::KIND_CHAR, ch);
      len = len + LEN_W'(1);
    end else if (len == LEN_LAST) begin
      push_res(a, b, n, csvft_pkg::KIND_OVERFLOW, 8'd0);
      len = LEN_OVF;
    end
  endfunction

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;
  assign acc       = in_tvalid && in_tready;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    in_header_nxt     = in_header_r;
    header_quoted_nxt = header_quoted_r;
    quoted_nxt        = quoted_r;
    quote_pending_nxt = quote_pending_r;
    flen_nxt          = flen_r;
    row_open_nxt      = row_open_r;
    n_res             = 2'd0;
    r0                = '0;
    r1                = '0;
    if (in_tlast) begin
      if (!in_header_r && (row_open_r || quoted_r || quote_pending_r || flen_r != '0)) begin
        push_res(r0, r1, n_res, csvft_pkg::KIND_ROW, 8'd0);
      end
      in_header_nxt     = skip_header_r;
      header_quoted_nxt = 1'b0;
      quoted_nxt        = 1'b0;
      quote_pending_nxt = 1'b0;
      flen_nxt          = '0;
      row_open_nxt      = 1'b0;
    end else if (in_header_r) begin
      if (in_tdata == csvft_pkg::CH_QUOTE) begin
        header_quoted_nxt = !header_quoted_r;
      end else if (in_tdata == csvft_pkg::CH_NEWLINE && !header_quoted_r) begin
        in_header_nxt = 1'b0;
      end
    end else begin
      row_open_nxt = 1'b1;
      if (quoted_r && quote_pending_r) begin
        quote_pending_nxt = 1'b0;
        if (in_tdata == csvft_pkg::CH_QUOTE) begin
          put_char(r0, r1, n_res, flen_nxt, csvft_pkg::CH_QUOTE);
        end else if (in_tdata == csvft_pkg::CH_COMMA ||
                     in_tdata == csvft_pkg::CH_NEWLINE) begin
          push_res(r0, r1, n_res,
                   (in_tdata == csvft_pkg::CH_NEWLINE) ? csvft_pkg::KIND_ROW
                                                      : csvft_pkg::KIND_FIELD, 8'd0);
          flen_nxt     = '0;
          quoted_nxt   = 1'b0;
          row_open_nxt = (in_tdata != csvft_pkg::CH_NEWLINE);
        end else begin
          put_char(r0, r1, n_res, flen_nxt, csvft_pkg::CH_QUOTE);
          put_char(r0, r1, n_res, flen_nxt, in_tdata);
        end
      end else if (quoted_r) begin
        if (in_tdata == csvft_pkg::CH_QUOTE) begin
          quote_pending_nxt = 1'b1;
        end else begin
          put_char(r0, r1, n_res, flen_nxt, in_tdata);
        end
      end else begin
        if (in_tdata == csvft_pkg::CH_QUOTE) begin
          quoted_nxt = 1'b1;
        end else if (in_tdata == csvft_pkg::CH_COMMA ||
                     in_tdata == csvft_pkg::CH_NEWLINE) begin
          push_res(r0, r1, n_res,
                   (in_tdata == csvft_pkg::CH_NEWLINE) ? csvft_pkg::KIND_ROW
                                                      : csvft_pkg::KIND_FIELD, 8'd0);
          flen_nxt     = '0;
          row_open_nxt = (in_tdata != csvft_pkg::CH_NEWLINE);
        end else begin
          put_char(r0, r1, n_res, flen_nxt, in_tdata);
        end
      end
    end
  end

  assign q_push   = acc && (n_res != 2'd0);
  assign q_ent.two = n_res[1];
  assign q_ent.r0  = r0;
  assign q_ent.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_header_r   <= 1'b1;
      in_header_r     <= 1'b1;
      header_quoted_r <= 1'b0;
      quoted_r        <= 1'b0;
      quote_pending_r <= 1'b0;
      flen_r          <= '0;
      row_open_r      <= 1'b0;
    end else if (cfg_wr) begin
      skip_header_r   <= cfg_data;
      in_header_r     <= cfg_data;
      header_quoted_r <= 1'b0;
      quoted_r        <= 1'b0;
      quote_pending_r <= 1'b0;
      flen_r          <= '0;
      row_open_r      <= 1'b0;
    end else if (acc) begin
      in_header_r     <= in_header_nxt;
      header_quoted_r <= header_quoted_nxt;
      quoted_r        <= quoted_nxt;
      quote_pending_r <= quote_pending_nxt;
      flen_r          <= flen_nxt;
      row_open_r      <= row_open_nxt;
    end
  end

  `CSVFT_ASSERT_NOW(a_len_bound, 1'b1, flen_r <= LEN_OVF, "field length past limit")
  `CSVFT_ASSERT_NOW(a_pend_quoted, quote_pending_r, quoted_r, "pending quote outside quotes")
  `CSVFT_ASSERT_NOW(a_hdr_silent, acc && in_header_r && !in_tlast, !q_push,
                    "result emitted from header")

endmodule

### sv/csvft_fifo.sv
module csvft_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  csvft_pkg::ent_t wr_ent,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output csvft_pkg::ent_t rd_ent
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  csvft_pkg::ent_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_ent    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

### sv/csvft_back.sv
`include "csv_field_tokenizer_defines.svh"

module csvft_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  csvft_pkg::ent_t q_ent,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  logic            valid_r;
  logic            sec_r;
  csvft_pkg::res_t cur_r;
  csvft_pkg::res_t hold_r;
  logic            last_r;
  logic            fire;
  logic            can_load;

  assign fire     = valid_r && out_tready;
  assign can_load = !valid_r || (fire && !sec_r);
  assign q_pop    = can_load && q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sec_r   <= 1'b0;
    end else if (fire && sec_r) begin
      sec_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      sec_r   <= q_ent.two;
    end else if (fire) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && sec_r) begin
      cur_r  <= hold_r;
      last_r <= 1'b1;
    end else if (q_pop) begin
      cur_r  <= q_ent.r0;
      hold_r <= q_ent.r1;
      last_r <= !q_ent.two;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = cur_r.ch;
  assign out_tuser  = cur_r.kind;
  assign out_tlast  = last_r;

  `CSVFT_ASSERT_NOW(a_sec_valid, sec_r, valid_r, "second result pending without output")
  `CSVFT_ASSERT_NOW(a_char_zero, valid_r && cur_r.kind != csvft_pkg::KIND_CHAR,
                    cur_r.ch == 8'd0, "nonzero char on mark")
  `CSVFT_ASSERT_NEXT(a_sec_last, fire && sec_r, valid_r && last_r,
                     "second result not shown as last")

endmodule

### sv/csv_field_tokenizer.sv
// A result is registered into the queue as its input transaction is taken, and is then
// loaded into the output register that drives out_*. Throughput: one input transaction
// per cycle; an item with two results is shown as two output transfers while the front
// keeps taking items into the QUEUE_DEPTH-entry queue until it fills.
// Reset: synchronous, active low; skip_header and in_header return to 1, other parser state clears.
`include "csv_field_tokenizer_defines.svh"

module csv_field_tokenizer #(
  parameter int MAX_FIELD   = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // text_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_char
  output logic [1:0] out_tuser,  // kind
  output logic       out_tlast,  // last_of_run
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data    // skip_header
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  csvft_pkg::ent_t q_wr_ent;
  csvft_pkg::ent_t q_rd_ent;

  csvft_front #(
    .MAX_FIELD(MAX_FIELD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ent     (q_wr_ent)
  );

  csvft_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_ent    (q_wr_ent),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_ent    (q_rd_ent)
  );

  csvft_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_ent       (q_rd_ent),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
